// ===== hdl/lpam_pkg.sv =====
// ----------------------------------------------------------------------------
// lpam_pkg
// Shared types, constants and register codes of the light pair armor matcher.
// ----------------------------------------------------------------------------
package lpam_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_LIGHTS = 8;
    localparam int DEF_COORD_BITS = 16;

    // Port widths fixed by the item formats
    localparam int FIELD_W   = 16;
    localparam int IN_DATA_W = 7 * FIELD_W;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_IDX_W  = 3;

    // Register widths
    localparam int RATIO_W = 9;
    localparam int DIST_W  = 12;
    localparam int TAN_W   = 16;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = LEN_W + 1;
    localparam int THR_W   = DIST_W + SUM_W;
    localparam int THR2_W  = 2 * THR_W;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_COLOR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RATIO    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SMALL_LOW    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SMALL_HIGH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LARGE_LOW    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LARGE_HIGH   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SLOPE    = 3'd6;

    // Register reset values
    localparam logic [RATIO_W-1:0] RST_MIN_RATIO  = 9'd179;
    localparam logic [DIST_W-1:0]  RST_SMALL_LOW  = 12'd205;
    localparam logic [DIST_W-1:0]  RST_SMALL_HIGH = 12'd819;
    localparam logic [DIST_W-1:0]  RST_LARGE_LOW  = 12'd819;
    localparam logic [DIST_W-1:0]  RST_LARGE_HIGH = 12'd1408;
    localparam logic [TAN_W-1:0]   RST_MAX_SLOPE  = 16'd179;

    // Light store read address source
    typedef enum logic [1:0] {
        RD_SEL_I = 2'd0,
        RD_SEL_J = 2'd1,
        RD_SEL_T = 2'd2
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    store;
        logic    pair_init;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    cap_b;
        logic    box;
        logic    scan_inc;
        logic    m1;
        logic    m2;
        logic    m3;
        logic    m4;
        logic    pend_load;
        logic    out_pend;
        logic    out_final;
        logic    advance;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pair_end;
        logic color_ok;
        logic hit;
        logic scan_last;
        logic match;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/lpam_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpam_ctrl
// Sequencer: light loading, pair walk, occlusion scan, arithmetic stages and
// result hand-off.
// ----------------------------------------------------------------------------
module lpam_ctrl
    import lpam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    typedef enum logic [15:0] {
        S_LOAD = 16'h0001,
        S_PCHK = 16'h0002,
        S_RDI  = 16'h0004,
        S_RDJ  = 16'h0008,
        S_CAPJ = 16'h0010,
        S_BOX  = 16'h0020,
        S_SRD  = 16'h0040,
        S_SCHK = 16'h0080,
        S_M1   = 16'h0100,
        S_M2   = 16'h0200,
        S_M3   = 16'h0400,
        S_M4   = 16'h0800,
        S_DEC  = 16'h1000,
        S_PUSH = 16'h2000,
        S_NEXT = 16'h4000,
        S_FIN  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_LOAD);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_SEL_I;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (in_last)
                    begin
                        cmd.pair_init = 1'b1;
                        state_next    = S_PCHK;
                    end
                end
            end
            S_PCHK:
            begin
                state_next = sts.pair_end ? S_FIN : S_RDI;
            end
            S_RDI:
            begin
                cmd.rd_sel = RD_SEL_I;
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                cmd.rd_sel = RD_SEL_J;
                cmd.cap_a  = 1'b1;
                state_next = S_CAPJ;
            end
            S_CAPJ:
            begin
                cmd.cap_b  = 1'b1;
                state_next = sts.color_ok ? S_BOX : S_NEXT;
            end
            S_BOX:
            begin
                cmd.box    = 1'b1;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.rd_sel = RD_SEL_T;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (sts.hit)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = sts.scan_last ? S_M1 : S_SRD;
                end
            end
            S_M1:
            begin
                cmd.m1     = 1'b1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.m2     = 1'b1;
                state_next = S_M3;
            end
            S_M3:
            begin
                cmd.m3     = 1'b1;
                state_next = S_M4;
            end
            S_M4:
            begin
                cmd.m4     = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.match && sts.pend_valid)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.pend_load = sts.match;
                    state_next    = S_NEXT;
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_pend  = 1'b1;
                    cmd.pend_load = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.advance = 1'b1;
                state_next  = S_PCHK;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_final = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ===== hdl/lpam_datapath.sv =====
// ----------------------------------------------------------------------------
// lpam_datapath
// Light store, configuration registers, pair counters, box test, ratio,
// distance and slope arithmetic, pending result and output register.
// ----------------------------------------------------------------------------
module lpam_datapath
    import lpam_pkg::*;
#(
    parameter int MAX_LIGHTS = DEF_MAX_LIGHTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [OUT_USER_W-1:0]  m_axis_tuser,
    output logic                   m_axis_tlast,
    input  cmd_t                   cmd,
    output status_t                sts
);

    localparam int CB    = COORD_BITS;
    localparam int IW    = $clog2(MAX_LIGHTS);
    localparam int CW    = $clog2(MAX_LIGHTS + 1);
    localparam int PW    = $clog2(MAX_LIGHTS + 2);
    localparam int SQ_W  = 2 * CB;
    localparam int NW    = SQ_W + 1;
    localparam int CMPW  = (NW + 18 > THR2_W) ? NW + 18 : THR2_W;

    typedef struct packed {
        logic              color;
        logic [LEN_W-1:0]  len;
        logic [CB-1:0]     by;
        logic [CB-1:0]     bx;
        logic [CB-1:0]     ty;
        logic [CB-1:0]     tx;
        logic [CB-1:0]     cy;
        logic [CB-1:0]     cx;
    } light_t;

    // Configuration registers
    logic               target_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [DIST_W-1:0]  sl_reg, sh_reg, ll_reg, lh_reg;
    logic [TAN_W-1:0]   tan_reg;

    // Frame state
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [IW-1:0] i_reg;
    logic [PW-1:0] j_reg;
    logic [IW-1:0] t_reg;

    // Light store
    light_t        mem [MAX_LIGHTS];
    light_t        rd_q;
    light_t        wr_rec;
    logic [IW-1:0] rd_addr;
    light_t        a_reg, b_reg;

    // Box bounds
    logic [CB:0] lox_reg, hix_reg, loy_reg, hiy_reg;

    // Arithmetic stages
    logic [CB-1:0]     dx_reg, dy_reg;
    logic [LEN_W-1:0]  short_reg, long_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   dx2_reg, dy2_reg;
    logic              len_pass_reg, slope_ok_reg;
    logic [THR_W-1:0]  rsl_reg, rsh_reg, rll_reg, rlh_reg;
    logic [CMPW-1:0]   norm_reg;
    logic [THR2_W-1:0] qsl_reg, qsh_reg, qll_reg, qlh_reg;
    logic              match_reg, large_reg;

    // Pending result and output register
    logic              pend_valid_reg;
    logic [IW-1:0]     pend_i_reg;
    logic [PW-1:0]     pend_j_reg;
    logic              pend_large_reg;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic              out_last_reg;

    logic [IW+OUT_IDX_W-1:0] pi_ext;
    logic [PW+OUT_IDX_W-1:0] pj_ext;

    function automatic logic [CB-1:0] crd(input logic [FIELD_W-1:0] f);
        logic [CB+FIELD_W-1:0] e;
        e = {{CB{1'b0}}, f};
        return e[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [CB-1:0] min4(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                           input logic [CB-1:0] c, input logic [CB-1:0] d);
        logic [CB-1:0] x, y;
        x = (a < b) ? a : b;
        y = (c < d) ? c : d;
        return (x < y) ? x : y;
    endfunction

    function automatic logic [CB-1:0] max4(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                           input logic [CB-1:0] c, input logic [CB-1:0] d);
        logic [CB-1:0] x, y;
        x = (a > b) ? a : b;
        y = (c > d) ? c : d;
        return (x > y) ? x : y;
    endfunction

    function automatic logic in_rng(input logic [CB-1:0] p, input logic [CB:0] lo,
                                    input logic [CB:0] hi);
        return ({1'b0, p} >= lo) && ({1'b0, p} < hi);
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 1'b0;
            ratio_reg  <= RST_MIN_RATIO;
            sl_reg     <= RST_SMALL_LOW;
            sh_reg     <= RST_SMALL_HIGH;
            ll_reg     <= RST_LARGE_LOW;
            lh_reg     <= RST_LARGE_HIGH;
            tan_reg    <= RST_MAX_SLOPE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET_COLOR: target_reg <= cfg_data[0];
                REG_MIN_RATIO:    ratio_reg  <= cfg_data[RATIO_W-1:0];
                REG_SMALL_LOW:    sl_reg     <= cfg_data[DIST_W-1:0];
                REG_SMALL_HIGH:   sh_reg     <= cfg_data[DIST_W-1:0];
                REG_LARGE_LOW:    ll_reg     <= cfg_data[DIST_W-1:0];
                REG_LARGE_HIGH:   lh_reg     <= cfg_data[DIST_W-1:0];
                REG_MAX_SLOPE:    tan_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Incoming light record
    always_comb
    begin
        wr_rec.cx    = crd(s_axis_tdata[0*FIELD_W +: FIELD_W]);
        wr_rec.cy    = crd(s_axis_tdata[1*FIELD_W +: FIELD_W]);
        wr_rec.tx    = crd(s_axis_tdata[2*FIELD_W +: FIELD_W]);
        wr_rec.ty    = crd(s_axis_tdata[3*FIELD_W +: FIELD_W]);
        wr_rec.bx    = crd(s_axis_tdata[4*FIELD_W +: FIELD_W]);
        wr_rec.by    = crd(s_axis_tdata[5*FIELD_W +: FIELD_W]);
        wr_rec.len   = s_axis_tdata[6*FIELD_W +: FIELD_W];
        wr_rec.color = s_axis_tuser;
    end

    // Read address selection
    always_comb
    begin
        case (cmd.rd_sel)
            RD_SEL_I: rd_addr = i_reg;
            RD_SEL_J: rd_addr = j_reg[IW-1:0];
            RD_SEL_T: rd_addr = t_reg;
            default:  rd_addr = i_reg;
        endcase
    end

    // Light store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_reg < CW'(MAX_LIGHTS)))
        begin
            mem[count_reg[IW-1:0]] <= wr_rec;
        end
        rd_q <= mem[rd_addr];
    end

    // Light count, overflow flag and pair walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            t_reg     <= '0;
        end
        else
        begin
            if (cmd.store)
            begin
                if (count_reg < CW'(MAX_LIGHTS))
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.out_final)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.pair_init)
            begin
                i_reg <= '0;
                j_reg <= PW'(1);
            end
            else if (cmd.advance)
            begin
                if ((j_reg + 1'b1) < PW'(count_reg))
                begin
                    j_reg <= j_reg + 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= PW'(i_reg) + PW'(2);
                end
            end
            if (cmd.box)
            begin
                t_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                t_reg <= t_reg + 1'b1;
            end
        end
    end

    // Pair capture and bounding box
    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            a_reg <= rd_q;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rd_q;
        end
        if (cmd.box)
        begin
            lox_reg <= {1'b0, min4(a_reg.tx, a_reg.bx, b_reg.tx, b_reg.bx) & ~CB'(15)};
            loy_reg <= {1'b0, min4(a_reg.ty, a_reg.by, b_reg.ty, b_reg.by) & ~CB'(15)};
            hix_reg <= {1'b0, max4(a_reg.tx, a_reg.bx, b_reg.tx, b_reg.bx) | CB'(15)}
                       + (CB+1)'(1);
            hiy_reg <= {1'b0, max4(a_reg.ty, a_reg.by, b_reg.ty, b_reg.by) | CB'(15)}
                       + (CB+1)'(1);
        end
    end

    // Arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.m1)
        begin
            dx_reg    <= absdiff(a_reg.cx, b_reg.cx);
            dy_reg    <= absdiff(a_reg.cy, b_reg.cy);
            short_reg <= (a_reg.len < b_reg.len) ? a_reg.len : b_reg.len;
            long_reg  <= (a_reg.len > b_reg.len) ? a_reg.len : b_reg.len;
            sum_reg   <= {1'b0, a_reg.len} + {1'b0, b_reg.len};
        end
        if (cmd.m2)
        begin
            dx2_reg      <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            dy2_reg      <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            len_pass_reg <= {short_reg, 8'd0} >
                            (25'(ratio_reg) * 25'(long_reg));
            slope_ok_reg <= (TAN_W+CB)'({dy_reg, 8'd0}) <
                            ((TAN_W+CB)'(tan_reg) * (TAN_W+CB)'(dx_reg));
            rsl_reg <= THR_W'(sl_reg) * THR_W'(sum_reg);
            rsh_reg <= THR_W'(sh_reg) * THR_W'(sum_reg);
            rll_reg <= THR_W'(ll_reg) * THR_W'(sum_reg);
            rlh_reg <= THR_W'(lh_reg) * THR_W'(sum_reg);
        end
        if (cmd.m3)
        begin
            norm_reg <= (CMPW'(dx2_reg) + CMPW'(dy2_reg)) << 18;
            qsl_reg  <= THR2_W'(rsl_reg) * THR2_W'(rsl_reg);
            qsh_reg  <= THR2_W'(rsh_reg) * THR2_W'(rsh_reg);
            qll_reg  <= THR2_W'(rll_reg) * THR2_W'(rll_reg);
            qlh_reg  <= THR2_W'(rlh_reg) * THR2_W'(rlh_reg);
        end
        if (cmd.m4)
        begin
            match_reg <= len_pass_reg && slope_ok_reg &&
                         ((norm_reg >= CMPW'(qsl_reg) && norm_reg < CMPW'(qsh_reg)) ||
                          (norm_reg >= CMPW'(qll_reg) && norm_reg < CMPW'(qlh_reg)));
            large_reg <= norm_reg > CMPW'(qll_reg);
        end
    end

    // Pending match and output register
    assign pi_ext = {{OUT_IDX_W{1'b0}}, pend_i_reg};
    assign pj_ext = {{OUT_IDX_W{1'b0}}, pend_j_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.out_pend || cmd.out_final)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.out_final)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_load)
        begin
            pend_i_reg     <= i_reg;
            pend_j_reg     <= j_reg;
            pend_large_reg <= large_reg;
        end
        if (cmd.out_pend || cmd.out_final)
        begin
            out_last_reg <= cmd.out_final;
            if (pend_valid_reg)
            begin
                out_data_reg <= {1'b0, ovf_reg, pj_ext[OUT_IDX_W-1:0], pi_ext[OUT_IDX_W-1:0]};
                out_user_reg <= {pend_large_reg, 1'b1};
            end
            else
            begin
                out_data_reg <= {1'b0, ovf_reg, {(2*OUT_IDX_W){1'b0}}};
                out_user_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Status to the controller
    always_comb
    begin
        sts.pair_end   = j_reg >= PW'(count_reg);
        sts.color_ok   = (a_reg.color == target_reg) && (rd_q.color == target_reg);
        sts.hit        = !((rd_q.cx == a_reg.cx && rd_q.cy == a_reg.cy) ||
                           (rd_q.cx == b_reg.cx && rd_q.cy == b_reg.cy)) &&
                         ((in_rng(rd_q.tx, lox_reg, hix_reg) && in_rng(rd_q.ty, loy_reg, hiy_reg)) ||
                          (in_rng(rd_q.bx, lox_reg, hix_reg) && in_rng(rd_q.by, loy_reg, hiy_reg)) ||
                          (in_rng(rd_q.cx, lox_reg, hix_reg) && in_rng(rd_q.cy, loy_reg, hiy_reg)));
        sts.scan_last  = (CW'(t_reg) + 1'b1) == count_reg;
        sts.match      = match_reg;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || m_axis_tready;
    end

    // Checks on frame bookkeeping
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LIGHTS))
        else $error("light count above storage depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CW'(MAX_LIGHTS))
        else $error("overflow flagged with free storage");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_final |=> (count_reg == '0) && !pend_valid_reg && !ovf_reg)
        else $error("frame state not cleared after final result");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_pend || cmd.out_final) |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten before transfer");

endmodule

// ===== hdl/light_pair_armor_matcher.sv =====
// ----------------------------------------------------------------------------
// light_pair_armor_matcher
// Collects light bars of one frame and reports matched armor pairs.
// ----------------------------------------------------------------------------
// Usage:
// Lights arrive on the s_axis channel, one transfer each; tlast marks the
// final light of a frame. Lights beyond MAX_LIGHTS are dropped and flagged in
// lights_dropped of every result. After the final light the block stops
// accepting input and walks all pairs (i, j), i < j. A pair whose colours
// are not both the target colour is skipped; otherwise the occlusion scan
// runs over the N stored lights, then the arithmetic stages follow. The scan
// reads each stored light from the light store in turn and stops at the
// first other light found inside the pair's box.
// Each match leaves on the m_axis channel, tlast on the frame's final result;
// a frame with no match gives one empty result. A match is held back by one
// so that tlast can be set, and the search pauses while the output register
// is still full and the receiver stalls. Input is taken again as soon as the
// final result sits in the output register.
// Reset clears the light count, the flags and the registers to their
// defaults. Configuration writes (cfg_we, cfg_addr, cfg_data) act at once; the
// user must make them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module light_pair_armor_matcher
    import lpam_pkg::*;
#(
    parameter int MAX_LIGHTS = DEF_MAX_LIGHTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // centre x, centre y, top x, top y, bottom x, bottom y, bar_length
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // bar_color
    input  logic                  s_axis_tuser,
    // last_light
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // first_light[2:0], second_light[5:3], lights_dropped[6], zero[7]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // armor_valid[0], is_large[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // last_armor
    output logic                  m_axis_tlast
);

    cmd_t    cmd;
    status_t sts;

    // Sequencer
    lpam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    lpam_datapath #(
        .MAX_LIGHTS (MAX_LIGHTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== test/light_pair_armor_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pair_armor_matcher_tb
// Drives frames of light bars into the armor matcher and checks every
// reported pair against a behavioural predictor of the pairing rules.
// ----------------------------------------------------------------------------
module light_pair_armor_matcher_tb;
    import lpam_pkg::*;

    localparam int NLIGHT   = 8;
    localparam int PAIR_MAX = NLIGHT * (NLIGHT - 1) / 2;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [15:0] cx, cy, tx, ty, bx, by, len;
        logic        color;
        logic        last;
    } light_t;

    typedef struct {
        logic       valid;
        logic [2:0] first;
        logic [2:0] second;
        logic       big;
        logic       dropped;
        logic       last;
    } armor_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // Predictor copy of the registers and light store
    logic        p_color;
    logic [8:0]  p_ratio;
    logic [11:0] p_slo, p_shi, p_llo, p_lhi;
    logic [15:0] p_tan;
    light_t      p_store [NLIGHT];
    int          p_count;
    logic        p_over;

    armor_t armor_q[$];
    int     err_count;
    longint cycles;
    int     stall_mode;

    light_pair_armor_matcher u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // No gap mostly, short ones often, a few long ones; none at all when stall_mode is 0
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (stall_mode == 0) return 0;
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random back-pressure and result comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (gap_len() == 0);
    end

    always @(posedge clk)
    begin
        armor_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (armor_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                err_count++;
            end
            else
            begin
                e = armor_q.pop_front();
                if (m_axis_tuser[0] !== e.valid)
                begin
                    $error("armor_valid exp %0d got %0d", e.valid, m_axis_tuser[0]);
                    err_count++;
                end
                if (m_axis_tdata[2:0] !== e.first)
                begin
                    $error("first_light exp %0d got %0d", e.first, m_axis_tdata[2:0]);
                    err_count++;
                end
                if (m_axis_tdata[5:3] !== e.second)
                begin
                    $error("second_light exp %0d got %0d", e.second, m_axis_tdata[5:3]);
                    err_count++;
                end
                if (m_axis_tuser[1] !== e.big)
                begin
                    $error("is_large exp %0d got %0d", e.big, m_axis_tuser[1]);
                    err_count++;
                end
                if (m_axis_tdata[6] !== e.dropped)
                begin
                    $error("lights_dropped exp %0d got %0d", e.dropped, m_axis_tdata[6]);
                    err_count++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last_armor exp %0d got %0d", e.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Sign of dist^2 * 2^18 against (thr * length sum)^2
    function automatic int band_cmp(logic [63:0] norm2, logic [63:0] lsum,
                                    logic [11:0] thr);
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] l;
        r  = thr * lsum;
        r2 = r * r;
        if ((norm2 >> 46) != 0) return 1;
        l = norm2 << 18;
        if (l > r2) return 1;
        if (l < r2) return -1;
        return 0;
    endfunction

    function automatic logic point_in(logic [15:0] x, logic [15:0] y,
                                      logic [16:0] xl, logic [16:0] xh,
                                      logic [16:0] yl, logic [16:0] yh);
        return ({1'b0, x} >= xl) && ({1'b0, x} < xh)
            && ({1'b0, y} >= yl) && ({1'b0, y} < yh);
    endfunction

    // True when some other light sits inside the pair's pixel box
    function automatic logic box_occupied(int i, int j);
        logic [15:0] mnx, mxx, mny, mxy;
        logic [16:0] xl, xh, yl, yh;
        light_t a, b, t;
        a = p_store[i];
        b = p_store[j];
        mnx = a.tx; mxx = a.tx; mny = a.ty; mxy = a.ty;
        if (a.bx < mnx) mnx = a.bx; if (a.bx > mxx) mxx = a.bx;
        if (b.tx < mnx) mnx = b.tx; if (b.tx > mxx) mxx = b.tx;
        if (b.bx < mnx) mnx = b.bx; if (b.bx > mxx) mxx = b.bx;
        if (a.by < mny) mny = a.by; if (a.by > mxy) mxy = a.by;
        if (b.ty < mny) mny = b.ty; if (b.ty > mxy) mxy = b.ty;
        if (b.by < mny) mny = b.by; if (b.by > mxy) mxy = b.by;
        xl = {1'b0, mnx & 16'hFFF0};
        xh = {1'b0, mxx | 16'h000F} + 17'd1;
        yl = {1'b0, mny & 16'hFFF0};
        yh = {1'b0, mxy | 16'h000F} + 17'd1;
        for (int n = 0; n < p_count; n++)
        begin
            t = p_store[n];
            if ((t.cx == a.cx && t.cy == a.cy) || (t.cx == b.cx && t.cy == b.cy))
                continue;
            if (point_in(t.tx, t.ty, xl, xh, yl, yh)
                || point_in(t.bx, t.by, xl, xh, yl, yh)
                || point_in(t.cx, t.cy, xl, xh, yl, yh))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // 0 none, 1 small, 2 large
    function automatic int pair_kind(int i, int j);
        logic [63:0] l1, l2, sh, lo, dx, dy, n2, ls;
        logic len_pass, small_ok, large_ok, slope_ok;
        l1 = p_store[i].len;
        l2 = p_store[j].len;
        sh = (l1 < l2) ? l1 : l2;
        lo = (l1 < l2) ? l2 : l1;
        dx = (p_store[i].cx > p_store[j].cx) ? p_store[i].cx - p_store[j].cx
                                             : p_store[j].cx - p_store[i].cx;
        dy = (p_store[i].cy > p_store[j].cy) ? p_store[i].cy - p_store[j].cy
                                             : p_store[j].cy - p_store[i].cy;
        n2 = dx * dx + dy * dy;
        ls = l1 + l2;
        len_pass = sh * 256 > p_ratio * lo;
        small_ok = band_cmp(n2, ls, p_slo) >= 0 && band_cmp(n2, ls, p_shi) < 0;
        large_ok = band_cmp(n2, ls, p_llo) >= 0 && band_cmp(n2, ls, p_lhi) < 0;
        slope_ok = dy * 256 < p_tan * dx;
        if (!(len_pass && (small_ok || large_ok) && slope_ok)) return 0;
        return (band_cmp(n2, ls, p_llo) > 0) ? 2 : 1;
    endfunction

    // Store one light in the predictor and queue the frame's results at its end
    task automatic predict_light(light_t l);
        armor_t r;
        int     found;
        int     kind;
        found = 0;
        if (p_count < NLIGHT)
        begin
            p_store[p_count] = l;
            p_count++;
        end
        else
            p_over = 1'b1;
        if (!l.last) return;
        for (int i = 0; i < p_count; i++)
            for (int j = i + 1; j < p_count; j++)
            begin
                if (p_store[i].color != p_color || p_store[j].color != p_color)
                    continue;
                if (box_occupied(i, j)) continue;
                kind = pair_kind(i, j);
                if (kind != 0 && found < PAIR_MAX)
                begin
                    r.valid = 1'b1; r.first = i[2:0]; r.second = j[2:0];
                    r.big = (kind == 2); r.dropped = p_over; r.last = 1'b0;
                    armor_q.push_back(r);
                    found++;
                end
            end
        if (found == 0)
        begin
            r.valid = 1'b0; r.first = 3'd0; r.second = 3'd0;
            r.big = 1'b0; r.dropped = p_over; r.last = 1'b0;
            armor_q.push_back(r);
        end
        armor_q[armor_q.size() - 1].last = 1'b1;
        p_count = 0;
        p_over  = 1'b0;
    endtask

    // Send one light transfer after a random gap; valid stays up until the
    // next gap or the next drain
    task automatic send_light(light_t l);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {l.len, l.by, l.bx, l.ty, l.tx, l.cy, l.cx};
        s_axis_tuser  <= l.color;
        s_axis_tlast  <= l.last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_light(l);
    endtask

    // Wait until every result is in, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (armor_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_TARGET_COLOR: p_color = val[0];
            REG_MIN_RATIO:    p_ratio = val[8:0];
            REG_SMALL_LOW:    p_slo   = val[11:0];
            REG_SMALL_HIGH:   p_shi   = val[11:0];
            REG_LARGE_LOW:    p_llo   = val[11:0];
            REG_LARGE_HIGH:   p_lhi   = val[11:0];
            REG_MAX_SLOPE:    p_tan   = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic default_regs();
        write_reg(REG_TARGET_COLOR, 16'd0);
        write_reg(REG_MIN_RATIO, 16'(RST_MIN_RATIO));
        write_reg(REG_SMALL_LOW, 16'(RST_SMALL_LOW));
        write_reg(REG_SMALL_HIGH, 16'(RST_SMALL_HIGH));
        write_reg(REG_LARGE_LOW, 16'(RST_LARGE_LOW));
        write_reg(REG_LARGE_HIGH, 16'(RST_LARGE_HIGH));
        write_reg(REG_MAX_SLOPE, 16'(RST_MAX_SLOPE));
    endtask

    // Vertical bar at a pixel position, given length in pixels
    function automatic light_t make_bar(int x, int y, int len_px, logic color);
        light_t l;
        l.cx = 16'(x * 16);
        l.cy = 16'(y * 16);
        l.tx = l.cx;
        l.bx = l.cx;
        l.ty = 16'((y - len_px / 2) * 16);
        l.by = 16'((y + len_px / 2) * 16);
        l.len = 16'(len_px * 16);
        l.color = color;
        l.last = 1'b0;
        return l;
    endfunction

    function automatic light_t rand_light();
        light_t l;
        l.cx = 16'($urandom); l.cy = 16'($urandom); l.tx = 16'($urandom);
        l.ty = 16'($urandom); l.bx = 16'($urandom); l.by = 16'($urandom);
        l.len = 16'($urandom); l.color = 1'($urandom); l.last = 1'b0;
        return l;
    endfunction

    // Plausible frame: a row of bars with jittered spacing and size
    task automatic send_frame(int n, logic color, logic rnd);
        light_t l;
        int x, y;
        x = $urandom_range(20, 200);
        for (int k = 0; k < n; k++)
        begin
            y = $urandom_range(100, 110);
            if (rnd && $urandom_range(0, 9) == 0)
                l = rand_light();
            else
                l = make_bar(x, y, $urandom_range(18, 26),
                             ($urandom_range(0, 5) == 0) ? ~color : color);
            l.last = (k == n - 1);
            send_light(l);
            x += $urandom_range(10, 70);
        end
    endtask

    // Directed: extremes, each test passing and failing, special cases
    task automatic test_directed();
        light_t a, b, c;
        // Two small armor pairs, the second with wider spacing
        a = make_bar(100, 100, 20, 1'b0);
        b = make_bar(130, 100, 20, 1'b0);
        send_light(a); b.last = 1'b1; send_light(b);
        b = make_bar(160, 100, 20, 1'b0);
        send_light(a); b.last = 1'b1; send_light(b);
        // Ratio failure, zero lengths, zero dx, and a light inside the box
        b = make_bar(130, 100, 8, 1'b0);
        send_light(a); b.last = 1'b1; send_light(b);
        a.len = 0; b = make_bar(130, 100, 20, 1'b0); b.len = 0;
        send_light(a); b.last = 1'b1; send_light(b);
        a = make_bar(100, 100, 20, 1'b0); b = make_bar(100, 150, 20, 1'b0);
        send_light(a); b.last = 1'b1; send_light(b);
        c = make_bar(115, 100, 20, 1'b0);
        b = make_bar(130, 100, 20, 1'b0);
        send_light(a); send_light(c); b.last = 1'b1; send_light(b);
        // Other light sharing a pair centre is ignored
        c = a; c.color = 1'b1;
        send_light(a); send_light(c); b.last = 1'b1; send_light(b);
        // Extreme coordinates, single light frame
        a.cx = 16'hFFFF; a.cy = 16'hFFFF; a.tx = 16'hFFFF; a.ty = 16'h0000;
        a.bx = 16'h0000; a.by = 16'hFFFF; a.len = 16'hFFFF; a.color = 1'b1;
        a.last = 1'b1;
        send_light(a);
        drain();
        // Overflow: eleven lights, wrong colour pairs included
        send_frame(11, 1'b0, 1'b0);
        drain();
    endtask

    // Register extremes, each with a short run of frames
    task automatic test_settings();
        write_reg(REG_TARGET_COLOR, 16'd1);
        write_reg(REG_MIN_RATIO, 16'd0);
        write_reg(REG_SMALL_LOW, 16'd0);
        write_reg(REG_SMALL_HIGH, 16'd4095);
        write_reg(REG_LARGE_LOW, 16'd4095);
        write_reg(REG_LARGE_HIGH, 16'd4095);
        write_reg(REG_MAX_SLOPE, 16'hFFFF);
        for (int f = 0; f < 4; f++) send_frame($urandom_range(2, 8), 1'b1, 1'b1);
        drain();
        write_reg(REG_MIN_RATIO, 16'd256);
        write_reg(REG_LARGE_LOW, 16'd0);
        write_reg(REG_MAX_SLOPE, 16'd0);
        for (int f = 0; f < 3; f++) send_frame($urandom_range(2, 6), 1'b1, 1'b1);
        drain();
        write_reg(REG_MIN_RATIO, 16'd1);
        write_reg(REG_SMALL_HIGH, 16'd0);
        write_reg(REG_LARGE_HIGH, 16'd2000);
        write_reg(REG_MAX_SLOPE, 16'd1000);
        for (int f = 0; f < 3; f++) send_frame($urandom_range(2, 6), 1'b1, 1'b1);
        drain();
        default_regs();
    endtask

    // Random frames, mostly well-formed bars, some noise and overflows
    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 140)
        begin
            stall_mode = int'($urandom_range(0, 4) != 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11)
                                            : $urandom_range(1, 8);
            send_frame(n, p_color, 1'b1);
            sent += n;
        end
        stall_mode = 1;
    endtask

    initial
    begin
        err_count = 0; cycles = 0; stall_mode = 1;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
        p_color = 1'b0; p_ratio = RST_MIN_RATIO;
        p_slo = RST_SMALL_LOW; p_shi = RST_SMALL_HIGH;
        p_llo = RST_LARGE_LOW; p_lhi = RST_LARGE_HIGH;
        p_tan = RST_MAX_SLOPE; p_count = 0; p_over = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_random();
        drain();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
